/* sv/u8sd_pkg.sv */
// ----------------------------------------------------------------------------
// u8sd_pkg
// Shared types and constants of the strict UTF-8 decoder.
// ----------------------------------------------------------------------------
package u8sd_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned CP_W     = 21;
	localparam int unsigned CNT_W    = 3;
	localparam int unsigned HOLD_N   = 4;
	localparam int unsigned ODATA_W  = 24;

	localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;
	localparam logic [CP_W-1:0] MAX_CP         = 21'h10FFFF;
	localparam logic [CP_W-1:0] SURR_LO        = 21'h00D800;
	localparam logic [CP_W-1:0] SURR_HI        = 21'h00DFFF;
	localparam logic [CP_W-1:0] MIN_CP2        = 21'h000080;
	localparam logic [CP_W-1:0] MIN_CP3        = 21'h000800;
	localparam logic [CP_W-1:0] MIN_CP4        = 21'h010000;

	// Outcome of one decode step on the held bytes
	localparam logic [2:0] CK_EMPTY  = 3'd0; // nothing held
	localparam logic [2:0] CK_BADLEAD = 3'd1; // lead byte cannot start a sequence
	localparam logic [2:0] CK_SHORT  = 3'd2; // sequence still incomplete
	localparam logic [2:0] CK_GOOD   = 3'd3; // complete and valid
	localparam logic [2:0] CK_REJECT = 3'd4; // complete but malformed

	typedef logic [HOLD_N-1:0][BYTE_W-1:0] held_t;

	typedef struct packed {
		logic [2:0]       kind;
		logic [CP_W-1:0]  code_point;
		logic [CNT_W-1:0] drop;
	} chk_t;

endpackage

/* sv/u8sd_check.sv */
// ----------------------------------------------------------------------------
// u8sd_check
// Decode unit: classifies the held sequence and assembles its scalar.
// ----------------------------------------------------------------------------
module u8sd_check (
	input  u8sd_pkg::held_t            held,
	input  logic [u8sd_pkg::CNT_W-1:0] cnt,
	output u8sd_pkg::chk_t             res
);
	import u8sd_pkg::*;

	logic [BYTE_W-1:0] lead;
	logic [CNT_W-1:0]  len;
	logic              c1, c2, c3;
	logic [CP_W-1:0]   cp2, cp3, cp4;
	logic              ok;
	logic [CP_W-1:0]   cp_sel;

	// Sequence length announced by the lead byte
	always_comb begin
		lead = held[0];
		if (lead < 8'h80) begin
			len = 3'd1;
		end else if (lead >= 8'hC2 && lead <= 8'hDF) begin
			len = 3'd2;
		end else if (lead >= 8'hE0 && lead <= 8'hEF) begin
			len = 3'd3;
		end else if (lead >= 8'hF0 && lead <= 8'hF4) begin
			len = 3'd4;
		end else begin
			len = 3'd0;
		end
	end

	// Continuation marks and assembled scalars
	assign c1  = (held[1][7:6] == 2'b10);
	assign c2  = (held[2][7:6] == 2'b10);
	assign c3  = (held[3][7:6] == 2'b10);
	assign cp2 = {10'd0, lead[4:0], held[1][5:0]};
	assign cp3 = {5'd0, lead[3:0], held[1][5:0], held[2][5:0]};
	assign cp4 = {lead[2:0], held[1][5:0], held[2][5:0], held[3][5:0]};

	// Validity of a complete sequence
	always_comb begin
		case (len)
			3'd1: begin
				ok     = 1'b1;
				cp_sel = {13'd0, lead};
			end
			3'd2: begin
				ok     = c1 && (cp2 >= MIN_CP2);
				cp_sel = cp2;
			end
			3'd3: begin
				ok     = c1 && c2 && (cp3 >= MIN_CP3) && !(cp3 >= SURR_LO && cp3 <= SURR_HI);
				cp_sel = cp3;
			end
			3'd4: begin
				ok     = c1 && c2 && c3 && (cp4 >= MIN_CP4) && (cp4 <= MAX_CP);
				cp_sel = cp4;
			end
			default: begin
				ok     = 1'b0;
				cp_sel = REPLACEMENT_CP;
			end
		endcase
	end

	// Classify and pick the result and the bytes to drop
	always_comb begin
		res.code_point = REPLACEMENT_CP;
		res.drop       = 3'd1;
		if (cnt == 3'd0) begin
			res.kind = CK_EMPTY;
			res.drop = 3'd0;
		end else if (len == 3'd0) begin
			res.kind = CK_BADLEAD;
		end else if (cnt < len) begin
			res.kind = CK_SHORT;
			res.drop = cnt;
		end else if (ok) begin
			res.kind       = CK_GOOD;
			res.code_point = cp_sel;
			res.drop       = len;
		end else begin
			res.kind = CK_REJECT;
		end
	end

endmodule

/* sv/utf8_strict_decoder.sv */
// ----------------------------------------------------------------------------
// utf8_strict_decoder
// Strict UTF-8 to Unicode scalar decoder with replay after rejection.
// ----------------------------------------------------------------------------
// Flow: an accepted byte is appended to the held bytes and the sequencer
//   goes to run; each step of the shared decode unit then releases at most
//   one result into the output register, R = results per byte (0..4).
//   Input is not ready for the next byte until the sequencer is back in idle.
// Output stalls hold the sequencer; a result waits in the output register.
// Reset: arst_n clears the held count, sequencer and output valid.
module utf8_strict_decoder (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [7:0]                   s_axis_tdata,  // [7:0] in_byte
	input  logic                         s_axis_tlast,  // in_last
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [u8sd_pkg::ODATA_W-1:0] m_axis_tdata,  // [20:0] code_point, rest zero
	output logic                         m_axis_tuser,  // malformed
	output logic                         m_axis_tlast   // out_last
);
	import u8sd_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic             state_q, state_d;
	held_t            held_q;
	logic [CNT_W-1:0] cnt_q;
	logic             last_q;
	chk_t             chk;
	logic             out_free;
	logic             emit;
	logic             emit_bad;
	logic             emit_final;
	logic [CP_W-1:0]  emit_cp;
	logic [CNT_W-1:0] cnt_after;
	logic [CP_W-1:0]  ocp_q;
	logic             obad_q;
	logic             olast_q;
	logic             ovalid_q;
	logic             accept;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !ovalid_q || m_axis_tready;

	u8sd_check u_check (
		.held (held_q),
		.cnt  (cnt_q),
		.res  (chk)
	);

	// Decide one step of the sequencer
	always_comb begin
		emit       = 1'b0;
		emit_bad   = 1'b1;
		emit_cp    = REPLACEMENT_CP;
		cnt_after  = cnt_q - chk.drop;
		state_d    = state_q;
		if (state_q == ST_IDLE) begin
			if (accept) begin
				state_d = ST_RUN;
			end
		end else if (out_free) begin
			case (chk.kind)
				CK_EMPTY: begin
					state_d = ST_IDLE;
				end
				CK_SHORT: begin
					emit    = last_q;
					state_d = ST_IDLE;
					if (!last_q) begin
						cnt_after = cnt_q;
					end
				end
				CK_GOOD: begin
					emit     = 1'b1;
					emit_bad = 1'b0;
					emit_cp  = chk.code_point;
				end
				default: begin
					emit = 1'b1;
				end
			endcase
		end
		emit_final = last_q && ((cnt_after == 3'd0) || (chk.kind == CK_SHORT));
	end

	// Sequencer and held-byte count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				cnt_q  <= cnt_q + 3'd1;
				last_q <= s_axis_tlast;
			end else if (state_q == ST_RUN && out_free) begin
				cnt_q <= cnt_after;
			end
		end
	end

	// Append the new byte or shift out consumed bytes
	always_ff @(posedge clk) begin
		if (accept) begin
			held_q[cnt_q[1:0]] <= s_axis_tdata;
		end else if (state_q == ST_RUN && out_free && emit) begin
			for (int i = 0; i < HOLD_N; i++) begin
				if (i + int'(chk.drop) < HOLD_N) begin
					held_q[i] <= held_q[i + int'(chk.drop)];
				end
			end
		end
	end

	// Output register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (out_free) begin
			ovalid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && emit) begin
			ocp_q   <= emit_cp;
			obad_q  <= emit_bad;
			olast_q <= emit_final;
		end
	end

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = {{(ODATA_W - CP_W){1'b0}}, ocp_q};
	assign m_axis_tuser  = obad_q;
	assign m_axis_tlast  = olast_q;

	// Room for the next byte whenever input is open
	a_room_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> cnt_q < 3'd4)
		else $error("held buffer full while idle");

	// End of string empties the buffer
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && state_d == ST_IDLE && last_q) |=> cnt_q == 3'd0)
		else $error("bytes left after end of string");

	// Malformed results carry the replacement character
	a_bad_repl: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> ocp_q == REPLACEMENT_CP)
		else $error("malformed result without U+FFFD");

	// Emitted scalars stay in range and outside surrogates
	a_scalar: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (ocp_q <= MAX_CP) && !(ocp_q >= SURR_LO && ocp_q <= SURR_HI))
		else $error("invalid scalar emitted");

endmodule

/* dv/utf8_strict_decoder_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_strict_decoder_tb
// Self-checking bench for the strict UTF-8 decoder. Byte strings go in on the
// slave stream, and a predictor of the held-byte decoder computes the scalars
// that each accepted byte should release. A checker compares every output
// transaction with the oldest predicted scalar. The directed strings cover
// extreme forms, bad leads, rejections with replay and truncation. The random
// strings mix well-formed characters with malformed ones, and both sides
// stall at random, except over the last strings.
// ----------------------------------------------------------------------------
module utf8_strict_decoder_tb;
	import u8sd_pkg::*;

	typedef struct packed {
		logic [CP_W-1:0] code_point;
		logic            malformed;
		logic            out_last;
	} scalar_t;

	// Shapes of one random character
	typedef enum int {
		CH_ASCII, CH_TWO, CH_THREE, CH_FOUR, CH_NOISE,
		CH_BADCONT, CH_OVERLONG, CH_SURROGATE, CH_ABOVE, CH_CUT
	} char_kind_t;

	localparam int unsigned RAND_BYTES = 350;
	localparam int unsigned CALM_BYTES = 280;

	logic                clk;
	logic                arst_n;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [7:0]          s_axis_tdata;   // [7:0] in_byte
	logic                s_axis_tlast;   // in_last
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	logic [ODATA_W-1:0]  m_axis_tdata;   // [20:0] code_point, rest zero
	logic                m_axis_tuser;   // malformed
	logic                m_axis_tlast;   // out_last

	// Predictor state: bytes of the pending sequence
	logic [7:0]  pend_bytes[HOLD_N];
	int unsigned pend_cnt;
	scalar_t     scalar_q[$];
	logic [7:0]  str_bytes[$];

	scalar_t     want;
	int unsigned fail_cnt;
	int unsigned n_strings;
	int unsigned n_bytes;
	int unsigned n_results;
	int unsigned n_malformed;
	int unsigned rx_stall;
	logic        quiet_tail;

	utf8_strict_decoder dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #10 clk = ~clk;

	// Sequence length announced by a lead byte, 0 for a byte that cannot lead
	function automatic int unsigned lead_len(input logic [7:0] b);
		if (b < 8'h80) return 1;
		if (b >= 8'hC2 && b <= 8'hDF) return 2;
		if (b >= 8'hE0 && b <= 8'hEF) return 3;
		if (b >= 8'hF0 && b <= 8'hF4) return 4;
		return 0;
	endfunction

	// Validate a complete pending sequence and assemble its scalar
	function automatic logic full_ok(input int unsigned len, output logic [CP_W-1:0] cp);
		logic [31:0] acc;
		logic [31:0] floor_cp;
		cp = '0;
		if (len == 1) begin
			cp = CP_W'(pend_bytes[0]);
			return 1'b1;
		end
		if (len == 2) begin
			acc = 32'(pend_bytes[0] & 8'h1F);
			floor_cp = 32'(MIN_CP2);
		end else if (len == 3) begin
			acc = 32'(pend_bytes[0] & 8'h0F);
			floor_cp = 32'(MIN_CP3);
		end else begin
			acc = 32'(pend_bytes[0] & 8'h07);
			floor_cp = 32'(MIN_CP4);
		end
		for (int k = 1; k < len; k++) begin
			if (pend_bytes[k][7:6] != 2'b10) return 1'b0;
			acc = (acc << 6) | 32'(pend_bytes[k][5:0]);
		end
		if (acc < floor_cp) return 1'b0;
		if (acc >= 32'(SURR_LO) && acc <= 32'(SURR_HI)) return 1'b0;
		if (acc > 32'(MAX_CP)) return 1'b0;
		cp = acc[CP_W-1:0];
		return 1'b1;
	endfunction

	task automatic emit(input logic [CP_W-1:0] cp, input logic bad);
		scalar_q.push_back('{code_point: cp, malformed: bad, out_last: 1'b0});
		n_results++;
		if (bad) n_malformed++;
	endtask

	// Drop bytes from the front of the pending sequence
	task automatic drop_held(input int unsigned k);
		if (k >= pend_cnt) begin
			pend_cnt = 0;
		end else begin
			for (int i = 0; i + k < pend_cnt; i++) pend_bytes[i] = pend_bytes[i + k];
			pend_cnt -= k;
		end
	endtask

	// Predict the scalars released by one accepted byte
	task automatic predict_scalars(input logic [7:0] b, input logic lst);
		int unsigned len;
		int unsigned first;
		logic [CP_W-1:0] cp;
		logic waiting;
		first = scalar_q.size();
		if (pend_cnt < HOLD_N) begin
			pend_bytes[pend_cnt] = b;
			pend_cnt++;
		end
		waiting = 1'b0;
		while (pend_cnt > 0 && !waiting) begin
			len = lead_len(pend_bytes[0]);
			if (len == 0) begin
				emit(REPLACEMENT_CP, 1'b1);
				drop_held(1);
			end else if (pend_cnt < len) begin
				// cut short at end of string: one replacement covers it all
				if (lst) begin
					emit(REPLACEMENT_CP, 1'b1);
					pend_cnt = 0;
				end
				waiting = 1'b1;
			end else if (full_ok(len, cp)) begin
				emit(cp, 1'b0);
				drop_held(len);
			end else begin
				// reject, then replay the bytes after the lead
				emit(REPLACEMENT_CP, 1'b1);
				drop_held(1);
			end
		end
		if (lst) begin
			pend_cnt = 0;
			if (scalar_q.size() > first) scalar_q[$].out_last = 1'b1;
		end
	endtask

	// Send one byte, with an optional idle burst before it
	task automatic push_byte(input logic [7:0] b, input logic lst);
		if (!quiet_tail && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= lst;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		predict_scalars(b, lst);
		n_bytes++;
	endtask

	task automatic send_string();
		foreach (str_bytes[i]) push_byte(str_bytes[i], i == str_bytes.size() - 1);
		n_strings++;
	endtask

	// Append the encoding of cp in len bytes, overlong forms allowed
	task automatic put_seq(input logic [CP_W-1:0] cp, input int unsigned len);
		case (len)
			1: str_bytes.push_back(cp[7:0]);
			2: begin
				str_bytes.push_back({3'b110, cp[10:6]});
				str_bytes.push_back({2'b10, cp[5:0]});
			end
			3: begin
				str_bytes.push_back({4'b1110, cp[15:12]});
				str_bytes.push_back({2'b10, cp[11:6]});
				str_bytes.push_back({2'b10, cp[5:0]});
			end
			default: begin
				str_bytes.push_back({5'b11110, cp[20:18]});
				str_bytes.push_back({2'b10, cp[17:12]});
				str_bytes.push_back({2'b10, cp[11:6]});
				str_bytes.push_back({2'b10, cp[5:0]});
			end
		endcase
	endtask

	// Random scalar that needs exactly len bytes
	function automatic logic [CP_W-1:0] rand_scalar(input int unsigned len);
		logic [CP_W-1:0] cp;
		case (len)
			1: cp = CP_W'($urandom_range(0, 'h7F));
			2: cp = CP_W'($urandom_range('h80, 'h7FF));
			3: begin
				cp = CP_W'($urandom_range('h800, 'hFFFF));
				if (cp >= SURR_LO && cp <= SURR_HI) cp = cp + 21'h000800;
			end
			default: cp = CP_W'($urandom_range('h10000, 'h10FFFF));
		endcase
		return cp;
	endfunction

	task automatic add_char();
		char_kind_t kind;
		int unsigned r;
		int unsigned len;
		int unsigned start;
		r = $urandom_range(0, 99);
		len = $urandom_range(2, 4);
		start = str_bytes.size();
		if (r < 20)      kind = CH_ASCII;
		else if (r < 35) kind = CH_TWO;
		else if (r < 52) kind = CH_THREE;
		else if (r < 70) kind = CH_FOUR;
		else             kind = char_kind_t'(CH_NOISE + (r - 70) / 5);
		case (kind)
			CH_ASCII:  put_seq(rand_scalar(1), 1);
			CH_TWO:    put_seq(rand_scalar(2), 2);
			CH_THREE:  put_seq(rand_scalar(3), 3);
			CH_FOUR:   put_seq(rand_scalar(4), 4);
			CH_NOISE:  str_bytes.push_back(8'($urandom_range(0, 255)));
			CH_BADCONT: begin
				put_seq(rand_scalar(len), len);
				str_bytes[start + $urandom_range(1, len - 1)] = 8'($urandom_range(0, 255));
			end
			CH_OVERLONG: begin
				if (len == 2)      put_seq(CP_W'($urandom_range(0, 'h7F)), 2);
				else if (len == 3) put_seq(CP_W'($urandom_range(0, 'h7FF)), 3);
				else               put_seq(CP_W'($urandom_range(0, 'hFFFF)), 4);
			end
			CH_SURROGATE: put_seq(CP_W'($urandom_range(SURR_LO, SURR_HI)), 3);
			CH_ABOVE:     put_seq(CP_W'($urandom_range('h110000, 'h1FFFFF)), 4);
			default: begin
				// drop the tail of a valid sequence
				put_seq(rand_scalar(len), len);
				repeat ($urandom_range(1, len - 1)) void'(str_bytes.pop_back());
			end
		endcase
	endtask

	// Extreme one- and two-byte forms, the highest scalar and a real encoded U+FFFD
	task automatic test_valid_forms();
		str_bytes = '{8'h00, 8'h7F};               send_string();
		str_bytes = '{8'hC2, 8'h80, 8'hDF, 8'hBF}; send_string();
		str_bytes = '{8'hEF, 8'hBF, 8'hBD};        send_string();
		str_bytes = '{8'hF4, 8'h8F, 8'hBF, 8'hBF}; send_string();
	endtask

	task automatic test_bad_leads();
		str_bytes = '{8'h80, 8'hFF}; send_string();
	endtask

	// Surrogate, value above the range and bad continuation, each replayed
	task automatic test_rejections();
		// hold off until the output side has drained
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (scalar_q.size() != 0) @(posedge clk);
		str_bytes = '{8'hED, 8'hA0, 8'h80};        send_string();
		str_bytes = '{8'hF4, 8'h90, 8'h80, 8'h80}; send_string();
		str_bytes = '{8'hC2, 8'h41};               send_string();
	endtask

	task automatic test_truncation();
		str_bytes = '{8'hF0, 8'h90}; send_string();
	endtask

	task automatic test_random_strings();
		int unsigned sent;
		sent = 0;
		while (sent < RAND_BYTES) begin
			quiet_tail = (sent >= CALM_BYTES);
			str_bytes.delete();
			repeat ($urandom_range(1, 8)) add_char();
			sent += str_bytes.size();
			send_string();
		end
	endtask

	// Check each output transaction and drive the receiver stalls
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (scalar_q.size() == 0) begin
				$error("unexpected result: code_point %h", m_axis_tdata[CP_W-1:0]);
				fail_cnt++;
			end else begin
				want = scalar_q.pop_front();
				if (m_axis_tdata[CP_W-1:0] !== want.code_point) begin
					$error("code_point: expected %h, got %h", want.code_point,
						m_axis_tdata[CP_W-1:0]);
					fail_cnt++;
				end
				if (m_axis_tdata[ODATA_W-1:CP_W] !== '0) begin
					$error("tdata pad: expected 0, got %h", m_axis_tdata[ODATA_W-1:CP_W]);
					fail_cnt++;
				end
				if (m_axis_tuser !== want.malformed) begin
					$error("malformed: expected %b, got %b", want.malformed, m_axis_tuser);
					fail_cnt++;
				end
				if (m_axis_tlast !== want.out_last) begin
					$error("out_last: expected %b, got %b", want.out_last, m_axis_tlast);
					fail_cnt++;
				end
			end
		end
		if (rx_stall > 0) begin
			rx_stall--;
			m_axis_tready <= 1'b0;
		end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
			rx_stall = $urandom_range(1, 11) - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		m_axis_tready = 1'b0;
		pend_cnt = 0;
		fail_cnt = 0;
		n_strings = 0;
		n_bytes = 0;
		n_results = 0;
		n_malformed = 0;
		rx_stall = 0;
		quiet_tail = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_valid_forms();
		test_bad_leads();
		test_rejections();
		test_truncation();
		test_random_strings();

		// drain the remaining results
		s_axis_tvalid <= 1'b0;
		while (scalar_q.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);

		$display("Decoded %0d strings, %0d bytes in, %0d scalars out (%0d replacements).",
			n_strings, n_bytes, n_results, n_malformed);
		if (fail_cnt == 0)
			$display("utf8_strict_decoder_tb OK");
		else
			$display("utf8_strict_decoder_tb NOT OK");
		$finish;
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("Timeout with %0d results still pending.", scalar_q.size());
		$display("utf8_strict_decoder_tb NOT OK");
		$finish;
	end

endmodule

/* utf8_strict_decoder.f */
sv/u8sd_pkg.sv
sv/u8sd_check.sv
sv/utf8_strict_decoder.sv
dv/utf8_strict_decoder_tb.sv
